[rtl/fcsg_pkg.sv]
// Package for the filled circle span generator: widths, word types, register
// indexes and the command/status structs between controller and datapath.
// No dependencies.
`default_nettype none

package fcsg_pkg;

    localparam int COORD_BITS   = 11;          // clip registers and span fields
    localparam int CENTRE_BITS  = 13;          // signed centre coordinates
    localparam int RAD_BITS     = 5;           // radius field
    localparam int WALK_BITS    = 7;           // x in 0..32, y in -1..31, signed
    localparam int SUM_BITS     = 14;          // centre +/- offset, signed
    localparam int DEC_BITS     = 12;          // midpoint decision term, signed
    localparam int CNT_BITS     = 6;           // spans issued so far
    localparam int CFG_IDX_BITS = 2;
    localparam int MAX_SPANS    = 63;

    // room checks: a pair fits while n <= MAX-2, a single while n <= MAX-1
    localparam logic [CNT_BITS-1:0] CNT_PAIR_MAX = CNT_BITS'(MAX_SPANS - 2);
    localparam logic [CNT_BITS-1:0] CNT_ONE_MAX  = CNT_BITS'(MAX_SPANS - 1);

    typedef logic [COORD_BITS-1:0]         t_coord;
    typedef logic signed [CENTRE_BITS-1:0] t_centre;
    typedef logic [RAD_BITS-1:0]           t_radius;

    localparam t_coord COORD_MAX = '1;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_CLIP_LEFT   = 2'd0,
        REG_CLIP_RIGHT  = 2'd1,
        REG_CLIP_TOP    = 2'd2,
        REG_CLIP_BOTTOM = 2'd3
    } t_reg_idx;

    typedef struct packed {
        t_coord left;
        t_coord right;
        t_coord top;
        t_coord bottom;
    } t_clip;

    // clipped span, before the last-span mark is known
    typedef struct packed {
        t_coord row;
        t_coord col_lo;
        t_coord col_hi;
        logic   vis;
    } t_span;

    typedef struct packed {
        logic load;       // take a new circle, reset the walk
        logic emit;       // build a span from the current x/y
        logic use_mid;    // middle row (cy+-x, half width y) instead of cap
        logic neg;        // row below centre (cy - offset)
        logic set_prev;   // remember y as the last cap row pair
        logic adv;        // step the midpoint walk
        logic flush;      // push the held span out as the last one
    } t_cmd;

    typedef struct packed {
        logic cap_due;    // y changed since the last cap pair and room left
        logic mid_due;    // x != y
        logic x_pos;      // x > 0
        logic pair_room;
        logic one_room;
        logic walk_end;   // x > y
        logic gen_ok;     // a new span can be taken in
        logic out_free;   // output register free this cycle
    } t_stat;

endpackage

`default_nettype wire

[rtl/fcsg_in_if.sv]
// Input channel: circle centre and radius with valid/ready.
// Depends on fcsg_pkg.
`default_nettype none

interface fcsg_in_if import fcsg_pkg::*; ();
    logic    valid;
    logic    ready;
    t_centre center_x;
    t_centre center_y;
    t_radius radius;

    modport source (output valid, output center_x, output center_y, output radius,
                    input ready);
    modport sink   (input valid, input center_x, input center_y, input radius,
                    output ready);
endinterface

`default_nettype wire

[rtl/fcsg_out_if.sv]
// Output channel: one clipped span per word with valid/ready.
// Depends on fcsg_pkg.
`default_nettype none

interface fcsg_out_if import fcsg_pkg::*; ();
    logic   valid;
    logic   ready;
    t_coord span_row;
    t_coord span_start;
    t_coord span_end;
    logic   visible;
    logic   last_span;

    modport source (output valid, output span_row, output span_start, output span_end,
                    output visible, output last_span, input ready);
    modport sink   (input valid, input span_row, input span_start, input span_end,
                    input visible, input last_span, output ready);
endinterface

`default_nettype wire

[rtl/fcsg_cfg.sv]
// Clip rectangle registers and their write decode.
// Depends on fcsg_pkg.
`default_nettype none

module fcsg_cfg import fcsg_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_we,
    input  logic [CFG_IDX_BITS-1:0] i_idx,
    input  t_coord                  i_data,
    output t_clip                   o_clip
);

    t_clip r_clip;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clip.left   <= '0;
            r_clip.right  <= COORD_MAX;
            r_clip.top    <= '0;
            r_clip.bottom <= COORD_MAX;
        end else if (i_we) begin
            case (t_reg_idx'(i_idx))
                REG_CLIP_LEFT:   r_clip.left   <= i_data;
                REG_CLIP_RIGHT:  r_clip.right  <= i_data;
                REG_CLIP_TOP:    r_clip.top    <= i_data;
                REG_CLIP_BOTTOM: r_clip.bottom <= i_data;
                default: ;
            endcase
        end
    end

    assign o_clip = r_clip;

endmodule

`default_nettype wire

[rtl/fcsg_ctrl.sv]
// Controller: sequences the four span slots of each walk step and the flush.
// Depends on fcsg_pkg.
`default_nettype none

module fcsg_ctrl import fcsg_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    typedef enum logic [1:0] {S_IDLE, S_WALK, S_FLUSH} t_state;
    typedef enum logic [1:0] {PH_CAP_P, PH_CAP_M, PH_MID_P, PH_MID_M} t_phase;

    t_state r_state, n_state;
    t_phase r_ph, n_ph;
    t_cmd   cmd;

    always_comb begin
        n_state = r_state;
        n_ph    = r_ph;
        cmd     = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.load = 1'b1;
                    n_state  = S_WALK;
                    n_ph     = PH_CAP_P;
                end
            end
            S_WALK: begin
                if (i_stat.gen_ok) begin
                    case (r_ph)
                        PH_CAP_P: begin
                            if (i_stat.walk_end) begin
                                n_state = S_FLUSH;
                            end else if (i_stat.cap_due) begin
                                cmd.emit = 1'b1;
                                n_ph     = PH_CAP_M;
                            end else begin
                                n_ph = PH_MID_P;  // middle handled in this same cycle
                            end
                        end
                        PH_CAP_M: begin
                            cmd.emit     = 1'b1;
                            cmd.neg      = 1'b1;
                            cmd.set_prev = 1'b1;
                            n_ph         = PH_MID_P;
                        end
                        PH_MID_M: begin
                            cmd.emit    = 1'b1;
                            cmd.use_mid = 1'b1;
                            cmd.neg     = 1'b1;
                            cmd.adv     = 1'b1;
                            n_ph        = PH_CAP_P;
                        end
                        default: ;
                    endcase
                    // middle rows: from PH_MID_P, or straight on when no cap is due
                    if (r_ph == PH_MID_P ||
                        (r_ph == PH_CAP_P && !i_stat.walk_end && !i_stat.cap_due)) begin
                        if (i_stat.mid_due && i_stat.x_pos && i_stat.pair_room) begin
                            cmd.emit    = 1'b1;
                            cmd.use_mid = 1'b1;
                            n_ph        = PH_MID_M;
                        end else begin
                            // centre row goes out once, x = 0 makes it cy + x
                            if (i_stat.mid_due && !i_stat.x_pos && i_stat.one_room) begin
                                cmd.emit    = 1'b1;
                                cmd.use_mid = 1'b1;
                            end
                            cmd.adv = 1'b1;
                            n_ph    = PH_CAP_P;
                        end
                    end
                end
            end
            S_FLUSH: begin
                if (i_stat.out_free) begin
                    cmd.flush = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ph    <= PH_CAP_P;
        end else begin
            r_state <= n_state;
            r_ph    <= n_ph;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);
    assign o_cmd      = cmd;

endmodule

`default_nettype wire

[rtl/fcsg_dp.sv]
// Datapath: midpoint walk registers, span clipper, held span and output register.
// Depends on fcsg_pkg.
`default_nettype none

module fcsg_dp import fcsg_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cmd    i_cmd,
    output t_stat   o_stat,
    input  t_clip   i_clip,
    input  t_centre i_center_x,
    input  t_centre i_center_y,
    input  t_radius i_radius,
    input  logic    i_out_ready,
    output logic    o_out_valid,
    output t_coord  o_span_row,
    output t_coord  o_span_start,
    output t_coord  o_span_end,
    output logic    o_visible,
    output logic    o_last_span
);

    localparam logic signed [DEC_BITS-1:0] DEC_INIT     = DEC_BITS'(3);
    localparam logic signed [DEC_BITS-1:0] DEC_STEP_Y   = DEC_BITS'(14);
    localparam logic signed [DEC_BITS-1:0] DEC_STEP_X   = DEC_BITS'(6);
    localparam logic signed [WALK_BITS-1:0] WALK_ONE    = WALK_BITS'(1);
    localparam logic signed [WALK_BITS-1:0] PREV_NONE   = '1;   // -1

    t_centre                     r_cx, r_cy;
    logic signed [WALK_BITS-1:0] r_x, r_y, r_prev_y;
    logic signed [DEC_BITS-1:0]  r_dec;
    logic [CNT_BITS-1:0]         r_n;
    t_span                       r_pend;
    logic                        r_pend_v;
    t_span                       r_out;
    logic                        r_out_last;
    logic                        r_out_v;

    logic signed [DEC_BITS-1:0]  rad_d, x_d, y_d, dec_init, dec_nx;
    logic                        dec_ge;
    logic signed [WALK_BITS-1:0] a_off, b_off;
    logic signed [SUM_BITS-1:0]  row_s, xa_s, xb_s, cs, ce;
    logic signed [SUM_BITS-1:0]  c_l, c_r, c_t, c_b;
    logic                        rej;
    logic                        out_take, out_free;
    t_span                       span_nx;

    // walk arithmetic
    always_comb begin
        rad_d    = DEC_BITS'(i_radius);
        x_d      = DEC_BITS'(r_x);
        y_d      = DEC_BITS'(r_y);
        dec_init = DEC_INIT - (rad_d <<< 1);
        dec_ge   = !r_dec[DEC_BITS-1];
        if (dec_ge) begin
            dec_nx = r_dec + ((x_d - y_d) <<< 2) + DEC_STEP_Y;
        end else begin
            dec_nx = r_dec + (x_d <<< 2) + DEC_STEP_X;
        end
    end

    // span build and clip
    always_comb begin
        a_off = i_cmd.use_mid ? r_x : r_y;
        b_off = i_cmd.use_mid ? r_y : r_x;
        c_l   = SUM_BITS'(i_clip.left);
        c_r   = SUM_BITS'(i_clip.right);
        c_t   = SUM_BITS'(i_clip.top);
        c_b   = SUM_BITS'(i_clip.bottom);
        if (i_cmd.neg) begin
            row_s = SUM_BITS'(r_cy) - SUM_BITS'(a_off);
        end else begin
            row_s = SUM_BITS'(r_cy) + SUM_BITS'(a_off);
        end
        xa_s = SUM_BITS'(r_cx) - SUM_BITS'(b_off);
        xb_s = SUM_BITS'(r_cx) + SUM_BITS'(b_off);
        cs   = (xa_s < c_l) ? c_l : xa_s;
        ce   = (xb_s > c_r) ? c_r : xb_s;
        rej  = (row_s < c_t) || (row_s > c_b) || (xa_s > c_r) || (xb_s < c_l) || (cs > ce);
        span_nx = '0;
        if (!rej) begin
            span_nx.row    = row_s[COORD_BITS-1:0];
            span_nx.col_lo = cs[COORD_BITS-1:0];
            span_nx.col_hi = ce[COORD_BITS-1:0];
            span_nx.vis    = 1'b1;
        end
    end

    assign out_take = r_out_v && i_out_ready;
    assign out_free = !r_out_v || i_out_ready;

    always_comb begin
        o_stat.pair_room = (r_n <= CNT_PAIR_MAX);
        o_stat.one_room  = (r_n <= CNT_ONE_MAX);
        o_stat.cap_due   = (r_prev_y != r_y) && o_stat.pair_room;
        o_stat.mid_due   = (r_x != r_y);
        o_stat.x_pos     = (r_x != '0);
        o_stat.walk_end  = (r_x > r_y);
        o_stat.out_free  = out_free;
        o_stat.gen_ok    = !r_pend_v || out_free;
    end

    // walk state, loaded on each new circle
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cx     <= i_center_x;
            r_cy     <= i_center_y;
            r_x      <= '0;
            r_y      <= WALK_BITS'(i_radius);
            r_dec    <= dec_init;
            r_prev_y <= PREV_NONE;
            r_n      <= '0;
        end else begin
            if (i_cmd.adv) begin
                r_x   <= r_x + WALK_ONE;
                r_dec <= dec_nx;
                if (dec_ge) begin
                    r_y <= r_y - WALK_ONE;
                end
            end
            if (i_cmd.set_prev) begin
                r_prev_y <= r_y;
            end
            if (i_cmd.emit) begin
                r_n <= r_n + CNT_BITS'(1);
            end
        end
    end

    // one span held back so the final one can be marked at flush
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else if (i_cmd.emit) begin
            r_pend_v <= 1'b1;
            if (r_pend_v) begin
                r_out_v <= 1'b1;
            end else if (out_take) begin
                r_out_v <= 1'b0;
            end
        end else if (i_cmd.flush) begin
            r_pend_v <= 1'b0;
            r_out_v  <= 1'b1;
        end else if (out_take) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_pend <= span_nx;
            if (r_pend_v) begin
                r_out      <= r_pend;
                r_out_last <= 1'b0;
            end
        end else if (i_cmd.flush) begin
            r_out      <= r_pend;
            r_out_last <= 1'b1;
        end
    end

    assign o_out_valid  = r_out_v;
    assign o_span_row   = r_out.row;
    assign o_span_start = r_out.col_lo;
    assign o_span_end   = r_out.col_hi;
    assign o_visible    = r_out.vis;
    assign o_last_span  = r_out_last;

endmodule

`default_nettype wire

[rtl/filled_circle_span_generator_top.sv]
// Top level of the filled circle span generator.
// Depends on fcsg_pkg, fcsg_in_if, fcsg_out_if, fcsg_cfg, fcsg_ctrl, fcsg_dp.
//
//  channel | dir | handshake      | word
//  --------+-----+----------------+-----------------------------------------------
//  i_in    | in  | valid/ready    | center_x, center_y (13b signed), radius (5b)
//  o_out   | out | valid/ready    | span_row, span_start, span_end, visible, last
//  i_cfg_* | in  | write enable   | 2b register index, 11b clip value
//
// Sequence: one load, then the spans (at most 2r+1, two at radius 0), a step of
// its own for a walk step whose cap pair has no middle row beside it, one
// end-of-walk check and one flush. The single clip unit, one span a cycle while
// the output is not stalled, sets the pace.
// Reset: synchronous, active low; clip rectangle returns to 0..2047 both ways.
// Stalls: an output register and one held span sit behind the clipper; the walk
// pauses while both are full. A new circle is taken while the last word waits.
`default_nettype none

module filled_circle_span_generator_top import fcsg_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    fcsg_in_if.sink                 i_in,
    fcsg_out_if.source              o_out,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0] i_cfg_idx,
    input  t_coord                  i_cfg_data
);

    t_clip clip;
    t_cmd  cmd;
    t_stat stat;
    logic  in_ready;

    // clip rectangle, to be written only while idle; the user's duty, not checked
    fcsg_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_we),
        .i_idx   (i_cfg_idx),
        .i_data  (i_cfg_data),
        .o_clip  (clip)
    );

    // sequencer: cap pair, middle pair (or centre row), then walk step
    fcsg_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // walk registers, clipper and output staging
    fcsg_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_clip       (clip),
        .i_center_x   (i_in.center_x),
        .i_center_y   (i_in.center_y),
        .i_radius     (i_in.radius),
        .i_out_ready  (o_out.ready),
        .o_out_valid  (o_out.valid),
        .o_span_row   (o_out.span_row),
        .o_span_start (o_out.span_start),
        .o_span_end   (o_out.span_end),
        .o_visible    (o_out.visible),
        .o_last_span  (o_out.last_span)
    );

    assign i_in.ready = in_ready;

endmodule

`default_nettype wire

[rtl/fcsg_chk.sv]
// Port-level checks for the span generator, bound to the top level.
// Depends on fcsg_pkg and filled_circle_span_generator_top.
`default_nettype none

module fcsg_chk import fcsg_pkg::*; (
    input logic   i_clk,
    input logic   i_rst_n,
    input logic   i_in_valid,
    input logic   i_in_ready,
    input logic   i_out_valid,
    input logic   i_out_ready,
    input t_coord i_span_row,
    input t_coord i_span_start,
    input t_coord i_span_end,
    input logic   i_visible,
    input logic   i_last_span
);

    // a stalled word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_span_row) &&
            $stable(i_span_start) && $stable(i_span_end) && $stable(i_visible) &&
            $stable(i_last_span)))
        else $error("stalled span word changed");

    // one circle at a time
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("input ready right after a circle was taken");

    // a word that is not the last means the circle is still being walked
    a_no_take_mid_circle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_last_span) |-> !i_in_ready)
        else $error("input ready while a circle is unfinished");

    // rejected spans carry zero coordinates
    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_visible) |-> (i_span_row == '0 && i_span_start == '0 &&
            i_span_end == '0))
        else $error("rejected span with non-zero coordinates");

endmodule

bind filled_circle_span_generator_top fcsg_chk u_fcsg_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_span_row   (o_out.span_row),
    .i_span_start (o_out.span_start),
    .i_span_end   (o_out.span_end),
    .i_visible    (o_out.visible),
    .i_last_span  (o_out.last_span)
);

`default_nettype wire

[tb/fcsg_span_checker.sv]
`timescale 1ns / 1ps
// Span checker for the filled circle span generator: watches the circle,
// span and clip-write ports, predicts every span and compares it on arrival.
// Depends on fcsg_pkg, fcsg_in_if and fcsg_out_if.

module fcsg_span_checker import fcsg_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    fcsg_in_if                      in_mon,
    fcsg_out_if                     out_mon,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0] i_cfg_idx,
    input  t_coord                  i_cfg_data,
    output int                      o_fail_count,
    output int                      o_pending_spans
);

    localparam int REPORT_LIMIT = 200;

    typedef struct packed {
        t_coord row;
        t_coord col_first;
        t_coord col_last;
        logic   vis;
        logic   is_last;
    } t_span_word;

    t_coord     clip_l, clip_r, clip_t, clip_b;
    t_span_word expected_spans[$];
    int         fail_total = 0;
    int         reports    = 0;
    int         words_in   = 0;

    // clip one span against the rectangle; rejected spans are all zero
    function automatic t_span_word clip_span(int row, int xa, int xb);
        t_span_word w;
        int lo, hi, s, e;
        w  = '0;
        lo = (xa < xb) ? xa : xb;
        hi = (xa < xb) ? xb : xa;
        if (row < int'(clip_t) || row > int'(clip_b) || lo > int'(clip_r) || hi < int'(clip_l))
            return w;
        s = (lo < int'(clip_l)) ? int'(clip_l) : lo;
        e = (hi > int'(clip_r)) ? int'(clip_r) : hi;
        if (s > e)
            return w;
        w.row       = t_coord'(row);
        w.col_first = t_coord'(s);
        w.col_last  = t_coord'(e);
        w.vis       = 1'b1;
        return w;
    endfunction

    // midpoint walk: cap pair when y moves, middle pair while x < y
    task automatic trace_circle(input t_centre cx_w, input t_centre cy_w, input t_radius rad_w);
        t_span_word spans[$];
        t_span_word tail;
        int cx, cy, rad, x, y, dec, prev_y;
        cx     = int'(cx_w);
        cy     = int'(cy_w);
        rad    = int'(rad_w);
        prev_y = -1;
        y      = rad;
        dec    = 3 - 2 * rad;
        for (x = 0; x <= y; x++) begin
            if (prev_y != y && spans.size() + 2 <= MAX_SPANS) begin
                spans.push_back(clip_span(cy + y, cx - x, cx + x));
                spans.push_back(clip_span(cy - y, cx - x, cx + x));
                prev_y = y;
            end
            if (x != y) begin
                if (x > 0) begin
                    if (spans.size() + 2 <= MAX_SPANS) begin
                        spans.push_back(clip_span(cy + x, cx - y, cx + y));
                        spans.push_back(clip_span(cy - x, cx - y, cx + y));
                    end
                end else if (spans.size() + 1 <= MAX_SPANS) begin
                    spans.push_back(clip_span(cy, cx - y, cx + y));
                end
            end
            if (dec >= 0) begin
                y--;
                dec += -4 * y + 4;
            end
            dec += 4 * x + 6;
        end
        tail         = spans.pop_back();
        tail.is_last = 1'b1;
        spans.push_back(tail);
        foreach (spans[i])
            expected_spans.push_back(spans[i]);
    endtask

    task automatic check_field(input string field, input int want_v, input int got_v);
        if (want_v != got_v) begin
            fail_total++;
            if (reports < REPORT_LIMIT)
                $display("%0t: span word %0d %s expected %0d, got %0d",
                         $time, words_in, field, want_v, got_v);
            reports++;
        end
    endtask

    always @(posedge i_clk) begin
        t_span_word want;
        if (!i_rst_n) begin
            clip_l = '0;
            clip_r = COORD_MAX;
            clip_t = '0;
            clip_b = COORD_MAX;
            expected_spans.delete();
        end else begin
            // pop before push: a word leaving now never belongs to a circle taken now
            if (out_mon.valid && out_mon.ready) begin
                if (expected_spans.size() == 0) begin
                    fail_total++;
                    if (reports < REPORT_LIMIT)
                        $display({"%0t: span word %0d expected none, ",
                                  "got row %0d %0d..%0d vis %0b last %0b"},
                                 $time, words_in, out_mon.span_row, out_mon.span_start,
                                 out_mon.span_end, out_mon.visible, out_mon.last_span);
                    reports++;
                end else begin
                    want = expected_spans.pop_front();
                    check_field("span_row",   want.row,       out_mon.span_row);
                    check_field("span_start", want.col_first, out_mon.span_start);
                    check_field("span_end",   want.col_last,  out_mon.span_end);
                    check_field("visible",    want.vis,       out_mon.visible);
                    check_field("last_span",  want.is_last,   out_mon.last_span);
                end
                words_in++;
            end
            if (in_mon.valid && in_mon.ready)
                trace_circle(in_mon.center_x, in_mon.center_y, in_mon.radius);
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_CLIP_LEFT:   clip_l = i_cfg_data;
                    REG_CLIP_RIGHT:  clip_r = i_cfg_data;
                    REG_CLIP_TOP:    clip_t = i_cfg_data;
                    REG_CLIP_BOTTOM: clip_b = i_cfg_data;
                    default: ;
                endcase
            end
        end
        o_pending_spans <= expected_spans.size();
        o_fail_count    <= fail_total;
    end

endmodule

[tb/tb_filled_circle_span_generator_top.sv]
`timescale 1ns / 1ps
// Testbench top for the filled circle span generator: clock, reset, circle
// stimulus in bursts, a stalling span sink, clip phases and the verdict.
// Depends on fcsg_pkg, fcsg_in_if, fcsg_out_if, fcsg_span_checker and the block.

module tb_filled_circle_span_generator_top;
    import fcsg_pkg::*;

    // hang guard on the whole run
    localparam int LIMIT_NS   = 10_000_000;
    localparam int TAIL_WAIT  = 100;     // settle after the last span word
    localparam int HOLD_AFTER = 600;     // span words before the long hold-off
    localparam int HOLD_LEN   = 400;

    typedef enum int {RX_FULL, RX_COIN, RX_SPARSE, RX_TOGGLE} t_rx_mode;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n;
    logic                    cfg_we;
    logic [CFG_IDX_BITS-1:0] cfg_idx;
    t_coord                  cfg_data;
    int                      fail_count;
    int                      pending_spans;
    int                      burst_left = 0;

    fcsg_in_if  circle_ch ();
    fcsg_out_if span_ch ();

    filled_circle_span_generator_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (circle_ch),
        .o_out      (span_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    fcsg_span_checker span_chk (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .in_mon          (circle_ch),
        .out_mon         (span_ch),
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_data      (cfg_data),
        .o_fail_count    (fail_count),
        .o_pending_spans (pending_spans)
    );

    always #5 i_clk = ~i_clk;

    // Sender side. Everything moves on the rising edge by NBA; ready is
    // sampled right after the edge wakes us, so it is the pre-edge value.

    // after each accepted word: count down the burst, maybe drop valid for a gap
    task automatic pace_sender();
        int gap;
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(4) == 0) ? $urandom_range(40, 10) : $urandom_range(8, 1);
            case ($urandom_range(3))
                0:       gap = 0;                       // run straight on
                1:       gap = $urandom_range(4, 1);
                2:       gap = $urandom_range(30, 5);
                default: gap = $urandom_range(90, 30);  // longest gaps
            endcase
            if (gap > 0) begin
                circle_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    task automatic send_circle(input int cx, input int cy, input int rad);
        circle_ch.valid    <= 1'b1;
        circle_ch.center_x <= t_centre'(cx);
        circle_ch.center_y <= t_centre'(cy);
        circle_ch.radius   <= t_radius'(rad);
        @(posedge i_clk);
        while (!circle_ch.ready)
            @(posedge i_clk);
        pace_sender();
    endtask

    // hold the input until every predicted span word has been taken
    task automatic drain_spans();
        circle_ch.valid <= 1'b0;
        do
            @(posedge i_clk);
        while (pending_spans != 0);
    endtask

    // block is idle here; all four clip registers in consecutive cycles
    task automatic write_clip(input int l, input int r, input int t, input int b);
        cfg_we   <= 1'b1;
        cfg_idx  <= REG_CLIP_LEFT;
        cfg_data <= t_coord'(l);
        @(posedge i_clk);
        cfg_idx  <= REG_CLIP_RIGHT;
        cfg_data <= t_coord'(r);
        @(posedge i_clk);
        cfg_idx  <= REG_CLIP_TOP;
        cfg_data <= t_coord'(t);
        @(posedge i_clk);
        cfg_idx  <= REG_CLIP_BOTTOM;
        cfg_data <= t_coord'(b);
        @(posedge i_clk);
        cfg_we   <= 1'b0;
    endtask

    function automatic int pick_between(int lo, int hi);
        return lo + int'($urandom_range(hi - lo));
    endfunction

    // Mostly centres within a radius of the rectangle so the clamps get
    // exercised; the rest anywhere in the 13-bit range.
    task automatic run_phase(input int l, input int r, input int t, input int b, input int count);
        int lo_x, hi_x, lo_y, hi_y, cx, cy, rad, sel;
        drain_spans();
        write_clip(l, r, t, b);
        lo_x = ((l < r) ? l : r) - 35;
        hi_x = ((l < r) ? r : l) + 35;
        lo_y = ((t < b) ? t : b) - 35;
        hi_y = ((t < b) ? b : t) + 35;
        repeat (count) begin
            cx  = ($urandom_range(99) < 75) ? pick_between(lo_x, hi_x) : pick_between(-4096, 4095);
            cy  = ($urandom_range(99) < 75) ? pick_between(lo_y, hi_y) : pick_between(-4096, 4095);
            sel = $urandom_range(99);
            // keep most circles small; the radius-31 ones cost 63 words each
            if (sel < 80)      rad = $urandom_range(10);
            else if (sel < 95) rad = $urandom_range(30, 11);
            else               rad = 31;
            send_circle(cx, cy, rad);
        end
    endtask

    initial begin
        int l, r, t, b;
        i_rst_n            = 1'b0;
        cfg_we             = 1'b0;
        cfg_idx            = REG_CLIP_LEFT;
        cfg_data           = '0;
        circle_ch.valid    = 1'b0;
        circle_ch.center_x = '0;
        circle_ch.center_y = '0;
        circle_ch.radius   = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed, reset clip rectangle 0..2047 both ways
        send_circle(100, 100, 0);       // zero radius: centre row twice
        send_circle(100, 100, 1);
        send_circle(200, 300, 2);
        send_circle(1000, 1000, 31);    // largest circle, fully inside
        send_circle(0, 0, 31);          // upper-left quarter only
        send_circle(2047, 2047, 31);    // lower-right quarter only
        send_circle(-4096, -4096, 31);  // every row rejected
        send_circle(4095, 4095, 31);
        send_circle(-4096, 4095, 0);
        send_circle(4095, -4096, 5);
        send_circle(-31, 500, 31);      // just reaches column 0
        send_circle(-32, 500, 31);      // wholly left
        send_circle(2078, 500, 31);     // just reaches column 2047
        send_circle(2079, 500, 31);     // wholly right
        send_circle(500, -31, 31);      // top cap lands on row 0
        send_circle(500, 2078, 31);     // bottom cap lands on row 2047
        send_circle(-1, -1, 1);
        send_circle(1024, 1024, 7);
        send_circle(600, 600, 16);
        send_circle(0, 2047, 0);

        run_phase(0, 2047, 0, 2047, 45);
        l = $urandom_range(1500);
        t = $urandom_range(1500);
        r = l + $urandom_range(500);
        b = t + $urandom_range(500);
        run_phase(l, r, t, b, 50);
        run_phase(1000, 1000, 1000, 1000, 40);  // single-pixel window
        run_phase(0, 0, 0, 0, 40);
        run_phase(2047, 2047, 2047, 2047, 40);
        run_phase(1200, 800, 100, 1900, 45);    // left past right: all rejected
        run_phase(100, 1900, 900, 300, 40);     // top below bottom: all rejected
        l = $urandom_range(1000);
        t = $urandom_range(1000);
        r = l + $urandom_range(1047);
        b = t + $urandom_range(1047);
        run_phase(l, r, t, b, 60);
        // unordered random corners, any bit pattern
        run_phase($urandom_range(2047), $urandom_range(2047),
                  $urandom_range(2047), $urandom_range(2047), 50);

        drain_spans();
        repeat (TAIL_WAIT) @(posedge i_clk);
        if (fail_count == 0 && pending_spans == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // Receiver: segments of random length, each with its own stall pattern,
    // plus one long hold-off while circles are still being offered so the
    // output fills and the input backs up.
    initial begin
        t_rx_mode mode;
        int       seg_left;
        int       words_seen;
        int       hold_left;
        bit       hold_done;
        mode          = RX_FULL;
        seg_left      = 0;
        words_seen    = 0;
        hold_left     = 0;
        hold_done     = 1'b0;
        span_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (span_ch.valid && span_ch.ready)
                words_seen++;
            if (!hold_done && words_seen >= HOLD_AFTER && circle_ch.valid) begin
                hold_done = 1'b1;
                hold_left = HOLD_LEN;
            end
            if (hold_left > 0) begin
                hold_left--;
                span_ch.ready <= 1'b0;
            end else begin
                if (seg_left == 0) begin
                    mode     = t_rx_mode'($urandom_range(3));
                    seg_left = $urandom_range(64, 8);
                end
                seg_left--;
                case (mode)
                    RX_FULL:   span_ch.ready <= 1'b1;
                    RX_COIN:   span_ch.ready <= 1'($urandom_range(1));
                    RX_SPARSE: span_ch.ready <= ($urandom_range(3) == 0);
                    default:   span_ch.ready <= ~span_ch.ready;
                endcase
            end
        end
    end

    initial begin
        #(LIMIT_NS);
        $display("Test completed with failures");
        $finish;
    end

endmodule
